FILE: sv/pwab_pkg.sv
// Shared types and constants for the pixel write / alpha blend engine.
package pwab_pkg;

    localparam int POS_W      = 8;
    localparam int DIM_W      = 7;
    localparam int COLOR_W    = 32;
    localparam int ADDR_W     = 16;
    localparam int PIX_ADDR_W = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_ENABLE   = 2'd2;

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 7'd64;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 7'd64;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_BLEND = 1'b1;

    // classified request, front to back
    typedef struct packed {
        logic               ok;
        logic               opcode;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
    } t_req;

    typedef struct packed {
        logic                  accepted;
        logic [PIX_ADDR_W-1:0] pixel_address;
        logic [COLOR_W-1:0]    pixel_value;
    } t_res;

    typedef enum logic [1:0] {
        BE_CLEAR,
        BE_IDLE,
        BE_WRITE
    } t_be_state;

endpackage

FILE: sv/pixel_write_alpha_blend.sv
// Top level of the pixel write / alpha blend engine.
// Usage:
//   Input queue: drive opcode, pos_x, pos_y and color with push; a request is
//   taken at a clock edge where push is high and full is low.
//   Result queue: while empty is low the oldest result sits on o_accepted,
//   o_pixel_address and o_pixel_value; pop takes it.
//   Configuration: i_cfg_we with i_cfg_index (0 width, 1 height, 2 draw
//   enable) writes i_cfg_wdata at once; other indexes are ignored. Write
//   only while no request is in flight.
// Timing: the front clips and computes the address in the accept cycle and
//   queues the request; the back reads the stored pixel when it takes the
//   request and blends and writes it in BE_WRITE, which waits while the
//   result queue is full. The back takes no new request until it has
//   finished the read-modify-write of the last one.
// Reset: registers return to 64 x 64, drawing enabled; then the store is
//   zeroed one word a cycle, MAX_WIDTH*MAX_HEIGHT words (4096 by default),
//   with full held high.
// Stall: if pop stays low, two results queue, the back holds a third and two
//   more requests queue, then full rises until results drain.
module pixel_write_alpha_blend
    import pwab_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_opcode,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [COLOR_W-1:0]    i_color,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_accepted,
    output logic [PIX_ADDR_W-1:0] o_pixel_address,
    output logic [COLOR_W-1:0]    o_pixel_value
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int REQ_W = $bits(t_req);
    localparam int RES_W = $bits(t_res);

    t_req w_front_req;
    t_req w_back_req;
    t_res w_back_res;
    t_res w_out_res;
    logic w_req_push;
    logic w_req_full;
    logic w_req_empty;
    logic w_req_pop;
    logic w_res_push;
    logic w_res_full;
    logic w_clearing;

    pwab_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .push       (push),
        .i_opcode   (i_opcode),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_color    (i_color),
        .i_req_full (w_req_full),
        .i_clearing (w_clearing),
        .o_full     (full),
        .o_req_push (w_req_push),
        .o_req      (w_front_req)
    );

    pwab_fifo #(.W(REQ_W)) u_req_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_req_push),
        .i_data (w_front_req),
        .o_full (w_req_full),
        .i_pop  (w_req_pop),
        .o_empty(w_req_empty),
        .o_data (w_back_req)
    );

    pwab_back #(.DEPTH(DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_empty(w_req_empty),
        .i_req      (w_back_req),
        .o_req_pop  (w_req_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_res      (w_back_res),
        .o_clearing (w_clearing)
    );

    pwab_fifo #(.W(RES_W)) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_data (w_back_res),
        .o_full (w_res_full),
        .i_pop  (pop),
        .o_empty(empty),
        .o_data (w_out_res)
    );

    assign o_accepted      = w_out_res.accepted;
    assign o_pixel_address = w_out_res.pixel_address;
    assign o_pixel_value   = w_out_res.pixel_value;

endmodule

FILE: sv/pwab_fifo.sv
// Two-entry queue used between front and back and on the result side.
module pwab_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;
    logic         w_do_push;
    logic         w_do_pop;

    assign o_full    = (r_count == 2'd2);
    assign o_empty   = (r_count == 2'd0);
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_data    = r_data[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_do_push) r_wptr <= ~r_wptr;
            if (w_do_pop)  r_rptr <= ~r_rptr;
            if (w_do_push && !w_do_pop)      r_count <= r_count + 2'd1;
            else if (!w_do_push && w_do_pop) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) r_data[r_wptr] <= i_data;
    end

endmodule

FILE: sv/pwab_front.sv
// Front end: configuration registers, clipping and address computation.
module pwab_front
    import pwab_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  push,
    input  logic                  i_opcode,
    input  logic [POS_W-1:0]      i_pos_x,
    input  logic [POS_W-1:0]      i_pos_y,
    input  logic [COLOR_W-1:0]    i_color,
    input  logic                  i_req_full,
    input  logic                  i_clearing,
    output logic                  o_full,
    output logic                  o_req_push,
    output t_req                  o_req
);

    logic [DIM_W-1:0] r_screen_width;
    logic [DIM_W-1:0] r_screen_height;
    logic             r_draw_enable;

    logic [DIM_W-1:0]   w_w;
    logic [DIM_W-1:0]   w_h;
    logic               w_ok;
    logic [14:0]        w_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
            r_draw_enable   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata;
                CFG_DRAW_ENABLE:   r_draw_enable   <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // saturate the visible size at the store dimensions
    always_comb begin
        w_w = ({6'b0, r_screen_width} > 13'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_screen_width;
        w_h = ({6'b0, r_screen_height} > 13'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : r_screen_height;
    end

    assign w_ok   = r_draw_enable & (i_pos_x < {1'b0, w_w}) & (i_pos_y < {1'b0, w_h});
    assign w_prod = {7'b0, i_pos_y} * {8'b0, w_w};

    assign o_full     = i_req_full | i_clearing;
    assign o_req_push = push & ~o_full;

    always_comb begin
        o_req.ok     = w_ok;
        o_req.opcode = i_opcode;
        o_req.addr   = w_ok ? ({1'b0, w_prod} + {8'b0, i_pos_x}) : '0;
        o_req.color  = i_color;
    end

endmodule

FILE: sv/pwab_back.sv
// Back end: frame store, clearing pass and read-modify-write blend.
module pwab_back
    import pwab_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_empty,
    input  t_req i_req,
    output logic o_req_pop,
    input  logic i_res_full,
    output logic o_res_push,
    output t_res o_res,
    output logic o_clearing
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [COLOR_W-1:0] r_mem [DEPTH];
    logic [COLOR_W-1:0] r_rdata;

    t_be_state r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    t_req          r_cur, n_cur;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [COLOR_W-1:0] w_wdata;
    logic [AW-1:0]      w_req_idx;
    logic [AW-1:0]      w_cur_idx;
    logic [AW+ADDR_W-1:0] w_req_ext;
    logic [AW+ADDR_W-1:0] w_cur_ext;
    logic [COLOR_W-1:0] w_value;

    function automatic logic [7:0] mix(input logic [7:0] f, input logic [7:0] b,
                                       input logic [7:0] a);
        logic [15:0] s;
        s = {8'b0, f} * {8'b0, a} + {8'b0, b} * (16'd255 - {8'b0, a});
        return s[15:8];
    endfunction

    function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] bg,
                                                 input logic [COLOR_W-1:0] fg);
        logic [7:0] a;
        a = fg[31:24];
        if (a == 8'd0)   return bg;
        if (a == 8'hFF)  return fg;
        return {8'hFF, mix(fg[23:16], bg[23:16], a), mix(fg[15:8], bg[15:8], a),
                mix(fg[7:0], bg[7:0], a)};
    endfunction

    assign w_req_ext = {{AW{1'b0}}, i_req.addr};
    assign w_cur_ext = {{AW{1'b0}}, r_cur.addr};
    assign w_req_idx = w_req_ext[AW-1:0];
    assign w_cur_idx = w_cur_ext[AW-1:0];

    assign w_value = !r_cur.ok ? '0 :
                     (r_cur.opcode == OP_BLEND) ? blend(r_rdata, r_cur.color) : r_cur.color;

    assign o_res.accepted      = r_cur.ok;
    assign o_res.pixel_address = r_cur.addr[PIX_ADDR_W-1:0];
    assign o_res.pixel_value   = w_value;
    assign o_clearing          = (r_state == BE_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cur      = r_cur;
        o_req_pop  = 1'b0;
        o_res_push = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_clr;
        w_wdata    = '0;
        unique case (r_state)
            BE_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == LAST) n_state = BE_IDLE;
            end
            BE_IDLE: begin
                // take the request and read the background in the same cycle
                if (!i_req_empty) begin
                    o_req_pop = 1'b1;
                    n_cur     = i_req;
                    n_state   = BE_WRITE;
                end
            end
            BE_WRITE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    w_we       = r_cur.ok;
                    w_waddr    = w_cur_idx;
                    w_wdata    = w_value;
                    n_state    = BE_IDLE;
                end
            end
            default: n_state = BE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_waddr] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (o_req_pop) r_rdata <= r_mem[w_req_idx];
    end

endmodule

FILE: tb/tb_pixel_write_alpha_blend.sv
// Self-checking testbench for pixel_write_alpha_blend: directed and random pixel requests.
module tb_pixel_write_alpha_blend;
    import pwab_pkg::*;

    localparam int FB_W           = 64;
    localparam int FB_H           = 64;
    localparam int FB_DEPTH       = FB_W * FB_H;
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_LEN       = 200;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int N_SEGS         = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic                  opcode;
        logic [POS_W-1:0]      pos_x;
        logic [POS_W-1:0]      pos_y;
        logic [COLOR_W-1:0]    color;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        bit                    fixed;
        t_res                  result;
    } t_row;

    // random segments: screen setting, request count
    int seg_width[N_SEGS]  = '{64, 127, 9, 1, 0, 40, 64, 64};
    int seg_height[N_SEGS] = '{64, 100, 5, 1, 64, 27, 64, 33};
    int seg_enable[N_SEGS] = '{1, 1, 1, 1, 1, 1, 0, 1};
    int seg_items[N_SEGS]  = '{400, 300, 300, 150, 100, 450, 100, 125};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  push        = 1'b0;
    logic                  pop         = 1'b0;
    logic                  i_opcode    = OP_WRITE;
    logic [POS_W-1:0]      i_pos_x     = '0;
    logic [POS_W-1:0]      i_pos_y     = '0;
    logic [COLOR_W-1:0]    i_color     = '0;
    logic                  full;
    logic                  empty;
    logic                  o_accepted;
    logic [PIX_ADDR_W-1:0] o_pixel_address;
    logic [COLOR_W-1:0]    o_pixel_value;

    // table expectation travels with the request it belongs to
    bit   drv_fixed  = 1'b0;
    t_res drv_result = '0;

    t_row directed_rows[$];
    t_res pending_pixels[$];

    logic [COLOR_W-1:0] frame_mirror[FB_DEPTH];
    logic [DIM_W-1:0]   width_reg  = SCREEN_WIDTH_RST;
    logic [DIM_W-1:0]   height_reg = SCREEN_HEIGHT_RST;
    logic               enable_reg = 1'b1;

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;

    pixel_write_alpha_blend DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_opcode       (i_opcode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_color        (i_color),
        .empty          (empty),
        .pop            (pop),
        .o_accepted     (o_accepted),
        .o_pixel_address(o_pixel_address),
        .o_pixel_value  (o_pixel_value)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] mix_chan(logic [7:0] fg, logic [7:0] bg, logic [7:0] a);
        int unsigned sum;
        sum = int'(fg) * int'(a) + int'(bg) * (255 - int'(a));
        return 8'(sum >> 8);
    endfunction

    function automatic logic [COLOR_W-1:0] src_over(logic [COLOR_W-1:0] bg,
                                                   logic [COLOR_W-1:0] fg);
        logic [7:0] a;
        a = fg[31:24];
        if (a == 8'h00) return bg;
        if (a == 8'hFF) return fg;
        return {8'hFF, mix_chan(fg[23:16], bg[23:16], a), mix_chan(fg[15:8], bg[15:8], a),
                mix_chan(fg[7:0], bg[7:0], a)};
    endfunction

    // clip, address, and update the mirrored frame store
    function automatic t_res paint_pixel(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                         logic [COLOR_W-1:0] color);
        int unsigned w;
        int unsigned h;
        int unsigned addr;
        t_res        r;
        w = (width_reg > FB_W) ? FB_W : width_reg;
        h = (height_reg > FB_H) ? FB_H : height_reg;
        r = '0;
        if (!enable_reg || x >= w || y >= h) return r;
        addr = y * w + x;
        if (addr >= FB_DEPTH) addr = FB_DEPTH - 1;
        if (op == OP_BLEND) frame_mirror[addr] = src_over(frame_mirror[addr], color);
        else frame_mirror[addr] = color;
        r.accepted      = 1'b1;
        r.pixel_address = PIX_ADDR_W'(addr);
        r.pixel_value   = frame_mirror[addr];
        return r;
    endfunction

    function automatic void row_item(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                     logic [COLOR_W-1:0] color);
        t_row row;
        row        = '{kind: ROW_ITEM, default: '0};
        row.opcode = op;
        row.pos_x  = x;
        row.pos_y  = y;
        row.color  = color;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_fixed(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                      logic [COLOR_W-1:0] color, logic acc,
                                      logic [PIX_ADDR_W-1:0] addr, logic [COLOR_W-1:0] value);
        t_row row;
        row        = '{kind: ROW_ITEM, default: '0};
        row.opcode = op;
        row.pos_x  = x;
        row.pos_y  = y;
        row.color  = color;
        row.fixed  = 1'b1;
        row.result = '{accepted: acc, pixel_address: addr, pixel_value: value};
        directed_rows.push_back(row);
    endfunction

    function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row row;
        row           = '{kind: ROW_CFG, default: '0};
        row.cfg_index = idx;
        row.cfg_data  = data;
        directed_rows.push_back(row);
    endfunction

    task automatic send_pixel(logic op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                              logic [COLOR_W-1:0] color, bit fixed, t_res result);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_opcode   <= op;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_color    <= color;
        drv_fixed  <= fixed;
        drv_result <= result;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // stop offering and wait until every pending result is back
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
        $error("%s: expected %0h, got %0h", field, want, got);
        mismatch_count++;
    endtask

    // request monitor and predictor
    always @(posedge i_clk) begin : request_mon
        t_res predicted;
        if (!i_rst_n) begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
            enable_reg <= 1'b1;
            for (int i = 0; i < FB_DEPTH; i++) frame_mirror[i] = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  <= i_cfg_wdata;
                    CFG_SCREEN_HEIGHT: height_reg <= i_cfg_wdata;
                    CFG_DRAW_ENABLE:   enable_reg <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (push && !full) begin
                predicted = paint_pixel(i_opcode, i_pos_x, i_pos_y, i_color);
                pending_pixels.push_back(drv_fixed ? drv_result : predicted);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && pop && !empty) begin
            if (pending_pixels.size() == 0) begin
                flag_mismatch("unrequested result, pixel_address", '0, o_pixel_address);
            end else begin
                want = pending_pixels.pop_front();
                if (o_accepted !== want.accepted)
                    flag_mismatch("accepted", want.accepted, o_accepted);
                if (o_pixel_address !== want.pixel_address)
                    flag_mismatch("pixel_address", want.pixel_address, o_pixel_address);
                if (o_pixel_value !== want.pixel_value)
                    flag_mismatch("pixel_value", want.pixel_value, o_pixel_value);
            end
        end
    end

    // result side: random pop, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_LEN;
            pop       <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            pop       <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_row               row;
        int                 r;
        int                 w_lim;
        int                 h_lim;
        logic               op;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [COLOR_W-1:0] color;

        // reset: 64 x 64, drawing on, store cleared
        row_fixed(OP_WRITE, 8'd0, 8'd0, 32'h0000_0000, 1'b1, 12'd0, 32'h0000_0000);
        row_fixed(OP_WRITE, 8'd63, 8'd63, 32'hFFFF_FFFF, 1'b1, 12'd4095, 32'hFFFF_FFFF);
        row_fixed(OP_WRITE, 8'd64, 8'd0, 32'h1234_5678, 1'b0, 12'd0, 32'h0);
        row_fixed(OP_WRITE, 8'd0, 8'd64, 32'h1234_5678, 1'b0, 12'd0, 32'h0);
        row_fixed(OP_BLEND, 8'd255, 8'd255, 32'hFFFF_FFFF, 1'b0, 12'd0, 32'h0);
        // alpha 0 keeps the background
        row_fixed(OP_BLEND, 8'd63, 8'd63, 32'h0012_3456, 1'b1, 12'd4095, 32'hFFFF_FFFF);
        // alpha 255 takes the foreground
        row_fixed(OP_BLEND, 8'd1, 8'd0, 32'hFFA5_C3E1, 1'b1, 12'd1, 32'hFFA5_C3E1);
        row_item(OP_BLEND, 8'd1, 8'd0, 32'h8000_0000);
        row_item(OP_BLEND, 8'd2, 8'd0, 32'h01FF_FFFF);
        row_item(OP_BLEND, 8'd2, 8'd0, 32'hFEFF_FFFF);
        row_fixed(OP_WRITE, 8'd5, 8'd3, 32'hAAAA_AAAA, 1'b1, 12'd197, 32'hAAAA_AAAA);
        row_fixed(OP_WRITE, 8'd5, 8'd3, 32'h5555_5555, 1'b1, 12'd197, 32'h5555_5555);
        row_item(OP_BLEND, 8'd5, 8'd3, 32'h7F0F_0F0F);
        row_fixed(OP_BLEND, 8'd0, 8'd1, 32'hFF00_0000, 1'b1, 12'd64, 32'hFF00_0000);
        row_fixed(OP_WRITE, 8'd128, 8'd1, 32'h0F0F_0F0F, 1'b0, 12'd0, 32'h0);
        row_item(OP_BLEND, 8'd10, 8'd20, 32'hC080_4020);
        // zero width drops everything
        row_cfg(CFG_SCREEN_WIDTH, 7'd0);
        row_fixed(OP_WRITE, 8'd0, 8'd0, 32'h1111_1111, 1'b0, 12'd0, 32'h0);
        // oversize saturates at the store size, stride included
        row_cfg(CFG_SCREEN_WIDTH, 7'd127);
        row_cfg(CFG_SCREEN_HEIGHT, 7'd127);
        row_fixed(OP_WRITE, 8'd63, 8'd63, 32'h89AB_CDEF, 1'b1, 12'd4095, 32'h89AB_CDEF);
        row_fixed(OP_WRITE, 8'd64, 8'd0, 32'h89AB_CDEF, 1'b0, 12'd0, 32'h0);
        row_cfg(CFG_SCREEN_WIDTH, 7'd1);
        row_cfg(CFG_SCREEN_HEIGHT, 7'd1);
        row_fixed(OP_WRITE, 8'd0, 8'd0, 32'h1357_9BDF, 1'b1, 12'd0, 32'h1357_9BDF);
        row_fixed(OP_WRITE, 8'd1, 8'd0, 32'h1357_9BDF, 1'b0, 12'd0, 32'h0);
        row_fixed(OP_BLEND, 8'd0, 8'd1, 32'h1357_9BDF, 1'b0, 12'd0, 32'h0);
        row_cfg(CFG_DRAW_ENABLE, 7'd0);
        row_fixed(OP_BLEND, 8'd0, 8'd0, 32'hFFFF_FFFF, 1'b0, 12'd0, 32'h0);
        // unknown index must leave the 7 x 5 screen alone
        row_cfg(CFG_SCREEN_WIDTH, 7'd7);
        row_cfg(CFG_SCREEN_HEIGHT, 7'd5);
        row_cfg(CFG_DRAW_ENABLE, 7'd1);
        row_cfg(CFG_UNUSED_IDX, 7'd0);
        row_fixed(OP_WRITE, 8'd6, 8'd4, 32'h2468_ACE0, 1'b1, 12'd34, 32'h2468_ACE0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 74;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
                write_reg(row.cfg_index, row.cfg_data);
            else
                send_pixel(row.opcode, row.pos_x, row.pos_y, row.color, row.fixed, row.result);
        end

        for (int seg = 0; seg < N_SEGS; seg++) begin
            write_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(seg_width[seg]));
            write_reg(CFG_SCREEN_HEIGHT, CFG_DATA_W'(seg_height[seg]));
            write_reg(CFG_DRAW_ENABLE, CFG_DATA_W'(seg_enable[seg]));
            w_lim = (seg_width[seg] > FB_W) ? FB_W : seg_width[seg];
            h_lim = (seg_height[seg] > FB_H) ? FB_H : seg_height[seg];
            if (seg < 2) begin
                send_idle_pct = 21;
                recv_idle_pct = 74;
            end else if (seg < 4) begin
                send_idle_pct = 74;
                recv_idle_pct = 21;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver stall while requests keep coming
            if (seg == 5) hold_reqs++;
            for (int n = 0; n < seg_items[seg]; n++) begin
                r = $urandom_range(99);
                if (r < 15) begin
                    // hot corner, so blends land on written pixels
                    x = POS_W'($urandom_range(3));
                    y = POS_W'($urandom_range(3));
                end else if (r < 85 && w_lim > 0 && h_lim > 0) begin
                    x = POS_W'($urandom_range(w_lim - 1));
                    y = POS_W'($urandom_range(h_lim - 1));
                end else begin
                    x = POS_W'($urandom_range(255));
                    y = POS_W'($urandom_range(255));
                end
                color = $urandom;
                r = $urandom_range(99);
                if (r < 20) color[31:24] = 8'h00;
                else if (r < 40) color[31:24] = 8'hFF;
                else if (r < 45) color[31:24] = 8'h01;
                else if (r < 50) color[31:24] = 8'hFE;
                op = ($urandom_range(1) == 1) ? OP_BLEND : OP_WRITE;
                send_pixel(op, x, y, color, 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pixels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
